// File: src/b32d_pkg.sv
// shared types and character constants for the base32 stream decoder
package b32d_pkg;

    localparam logic [7:0] PAD_CHAR   = 8'h3D;
    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [7:0] CR_CHAR    = 8'h0D;
    localparam logic [7:0] LF_CHAR    = 8'h0A;
    localparam logic [7:0] LOWER_A    = 8'h61;
    localparam logic [7:0] LOWER_Z    = 8'h7A;
    localparam logic [7:0] UPPER_A    = 8'h41;
    localparam logic [7:0] UPPER_Z    = 8'h5A;
    localparam logic [7:0] DIGIT_2    = 8'h32;
    localparam logic [7:0] DIGIT_7    = 8'h37;
    localparam logic [7:0] CASE_GAP   = 8'h20;
    localparam logic [7:0] DIGIT_BASE = 8'h18;  // '2' maps to 26: 0x32 - 26

    typedef enum logic [1:0] {
        SYM_SKIP,
        SYM_DATA,
        SYM_BAD
    } t_sym_kind;

    typedef struct packed {
        t_sym_kind  kind;
        logic [4:0] value;
    } t_sym;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       bad_char;
        logic       string_end;
    } t_result;

endpackage

// File: src/b32d_stream_if.sv
// valid/ready channels for characters in and decoded results out
interface b32d_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       is_last;

    modport source (output valid, output char_in, output is_last, input ready);
    modport sink   (input valid, input char_in, input is_last, output ready);
endinterface

interface b32d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       bad_char;
    logic       string_end;

    modport source (output valid, output data_byte, output byte_valid,
                    output bad_char, output string_end, input ready);
    modport sink   (input valid, input data_byte, input byte_valid,
                    input bad_char, input string_end, output ready);
endinterface

// File: src/base32_stream_decoder_top.sv
// top level of the base32 stream decoder: input register, decode, result register
//
//  channel   dir  beat payload                                   handshake
//  i_char    in   char_in[7:0], is_last                          valid/ready
//  o_byte    out  data_byte[7:0], byte_valid, bad_char,          valid/ready
//                 string_end
//
// one character per cycle sustained while the result channel is not stalled; a result
//   is offered after its character passes the input register, then the result register
// the decode is one lookup plus a 12-bit shift on the remainder register
// synchronous active-low reset empties both registers and the remainder state
// a stalled result holds in the result register; the input register still
//   takes a beat while it is empty, and characters that give no result drain
//   only when the result register can take a beat
module base32_stream_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    b32d_char_if.sink   i_char,
    b32d_byte_if.source o_byte
);
    import b32d_pkg::*;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_last;

    // result register
    logic    r_out_valid;
    t_result r_out_res;
    logic    n_out_valid;

    t_sym    sym;
    logic    emit;
    t_result res;
    logic    advance;

    // the registered character moves on once the result slot is free or draining
    assign advance      = r_in_valid && (!r_out_valid || o_byte.ready);
    assign i_char.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_char.ready) begin
            r_in_valid <= i_char.valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (i_char.ready && i_char.valid) begin
            r_in_char <= i_char.char_in;
            r_in_last <= i_char.is_last;
        end
    end

    b32d_symbol_map u_map (
        .i_char (r_in_char),
        .o_sym  (sym)
    );

    b32d_bit_packer u_packer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_sym   (sym),
        .i_last  (r_in_last),
        .o_emit  (emit),
        .o_res   (res)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = emit;
        end else if (o_byte.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out_res <= res;
        end
    end

    assign o_byte.valid      = r_out_valid;
    assign o_byte.data_byte  = r_out_res.data_byte;
    assign o_byte.byte_valid = r_out_res.byte_valid;
    assign o_byte.bad_char   = r_out_res.bad_char;
    assign o_byte.string_end = r_out_res.string_end;

endmodule

// File: src/b32d_symbol_map.sv
// character classifier: skip, alphabet symbol with its 5-bit value, or invalid
module b32d_symbol_map (
    input  logic [7:0]   i_char,
    output b32d_pkg::t_sym o_sym
);
    import b32d_pkg::*;

    logic [7:0] folded;
    logic [7:0] letter_off;
    logic [7:0] digit_off;

    always_comb begin
        folded = i_char;
        if (i_char >= LOWER_A && i_char <= LOWER_Z) begin
            folded = i_char - CASE_GAP;
        end
        letter_off = folded - UPPER_A;
        digit_off  = folded - DIGIT_BASE;

        o_sym.kind  = SYM_BAD;
        o_sym.value = '0;
        if (i_char == PAD_CHAR || i_char == SPACE_CHAR ||
            i_char == CR_CHAR || i_char == LF_CHAR) begin
            o_sym.kind = SYM_SKIP;
        end else if (folded >= UPPER_A && folded <= UPPER_Z) begin
            o_sym.kind  = SYM_DATA;
            o_sym.value = letter_off[4:0];
        end else if (folded >= DIGIT_2 && folded <= DIGIT_7) begin
            o_sym.kind  = SYM_DATA;
            o_sym.value = digit_off[4:0];
        end
    end

endmodule

// File: src/b32d_bit_packer.sv
// bit remainder and string failure state, byte assembly per symbol
module b32d_bit_packer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  b32d_pkg::t_sym    i_sym,
    input  logic              i_last,
    output logic              o_emit,
    output b32d_pkg::t_result o_res
);
    import b32d_pkg::*;

    logic [6:0] r_rem;
    logic [2:0] r_held;
    logic       r_failed;
    logic [6:0] n_rem;
    logic [2:0] n_held;
    logic       n_failed;

    logic [11:0] acc;
    logic [3:0]  nbits;
    logic [3:0]  nleft;
    logic [11:0] shifted;
    logic [4:0]  keep_mask;

    always_comb begin
        acc       = {r_rem, i_sym.value};
        nbits     = {1'b0, r_held} + 4'd5;
        nleft     = nbits - 4'd8;
        shifted   = acc >> nleft;
        keep_mask = 5'((6'd1 << nleft) - 6'd1);

        o_emit   = 1'b0;
        o_res    = '0;
        n_rem    = r_rem;
        n_held   = r_held;
        n_failed = r_failed;

        if (r_failed) begin
            if (i_last) begin
                o_emit         = 1'b1;
                o_res.bad_char = 1'b1;
            end
        end else begin
            unique case (i_sym.kind)
                SYM_SKIP: begin
                    o_emit = i_last;
                end
                SYM_BAD: begin
                    n_failed       = 1'b1;
                    o_emit         = 1'b1;
                    o_res.bad_char = 1'b1;
                end
                SYM_DATA: begin
                    if (nbits >= 4'd8) begin
                        o_emit           = 1'b1;
                        o_res.data_byte  = shifted[7:0];
                        o_res.byte_valid = 1'b1;
                        n_rem            = {2'b00, acc[4:0] & keep_mask};
                        n_held           = nleft[2:0];
                    end else begin
                        o_emit = i_last;
                        n_rem  = acc[6:0];
                        n_held = nbits[2:0];
                    end
                end
                default: begin
                    o_emit = 1'b0;
                end
            endcase
        end
        o_res.string_end = i_last;

        // every string starts from empty state
        if (i_last) begin
            n_rem    = '0;
            n_held   = '0;
            n_failed = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem    <= '0;
            r_held   <= '0;
            r_failed <= 1'b0;
        end else if (i_step) begin
            r_rem    <= n_rem;
            r_held   <= n_held;
            r_failed <= n_failed;
        end
    end

endmodule

// File: src/b32d_checker.sv
// port-level checks on the decoder result channel, bound to the top level
module b32d_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_data_byte,
    input logic       i_byte_valid,
    input logic       i_bad_char,
    input logic       i_string_end
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid &&
            $stable({i_data_byte, i_byte_valid, i_bad_char, i_string_end}))
        else $error("result beat changed while stalled");

    // a decoded byte never comes with an error flag
    a_byte_or_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_byte_valid && i_bad_char))
        else $error("byte and error flagged together");

    // results without a byte carry a zero data field
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_byte_valid |-> i_data_byte == 8'h00)
        else $error("nonzero data on a result without a byte");

    // every result is a byte, an error or a string end
    a_has_meaning: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_byte_valid || i_bad_char || i_string_end)
        else $error("result beat carries nothing");

endmodule

bind base32_stream_decoder_top b32d_checker u_b32d_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_byte.valid),
    .i_out_ready  (o_byte.ready),
    .i_data_byte  (o_byte.data_byte),
    .i_byte_valid (o_byte.byte_valid),
    .i_bad_char   (o_byte.bad_char),
    .i_string_end (o_byte.string_end)
);
